// ===== hdl/bcomp_pkg.sv =====
// bcomp_pkg: shared types, constants and the calibration byte decoder
// for the barometer compensation pipeline; no dependencies
package bcomp_pkg;

    localparam int CalBytes = 21;
    localparam int CalBits  = CalBytes * 8;

    // register indexes of the configuration port
    localparam logic [1:0] REG_CAL_LOW  = 2'd0;
    localparam logic [1:0] REG_CAL_MID  = 2'd1;
    localparam logic [1:0] REG_CAL_HIGH = 2'd2;

    localparam logic signed [15:0] TEMP_MIN  = -16'sd5000;
    localparam logic signed [15:0] TEMP_MAX  = 16'sd10000;
    localparam logic signed [31:0] PRESS_MAX = 32'sd200000;

    typedef struct packed {
        logic        [15:0] t1;
        logic        [15:0] t2;
        logic signed [7:0]  t3;
        logic signed [15:0] p1;
        logic signed [15:0] p2;
        logic signed [7:0]  p3;
        logic signed [7:0]  p4;
        logic        [15:0] p5;
        logic        [15:0] p6;
        logic signed [7:0]  p7;
        logic signed [7:0]  p8;
        logic signed [15:0] p9;
        logic signed [7:0]  p10;
        logic signed [7:0]  p11;
    } coef_t;

    // temperature stage to pressure stage
    typedef struct packed {
        logic               valid;
        logic signed [25:0] tl;
        logic        [23:0] rp;
        logic signed [14:0] cdeg;
        logic               tflag;
    } tbeat_t;

    function automatic coef_t decode_coef(input logic [CalBits-1:0] cal);
        coef_t c;
        c.t1  = cal[0*8 +: 16];
        c.t2  = cal[2*8 +: 16];
        c.t3  = cal[4*8 +: 8];
        c.p1  = cal[5*8 +: 16];
        c.p2  = cal[7*8 +: 16];
        c.p3  = cal[9*8 +: 8];
        c.p4  = cal[10*8 +: 8];
        c.p5  = cal[11*8 +: 16];
        c.p6  = cal[13*8 +: 16];
        c.p7  = cal[15*8 +: 8];
        c.p8  = cal[16*8 +: 8];
        c.p9  = cal[17*8 +: 16];
        c.p10 = cal[19*8 +: 8];
        c.p11 = cal[20*8 +: 8];
        return c;
    endfunction

endpackage

// ===== hdl/bcomp_temp_pipe.sv =====
// bcomp_temp_pipe: five-stage linearized temperature pipeline
// depends on bcomp_pkg (coef_t, tbeat_t, temperature limits)
module bcomp_temp_pipe
    import bcomp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [23:0] raw_temp,
    input  logic [23:0] raw_press,
    input  coef_t       coef,
    output tbeat_t      tout
);

    localparam logic signed [61:0] TN_LIM = 62'sd1 <<< 55;
    localparam logic signed [29:0] TL_LIM = 30'sd1 <<< 24;
    localparam logic signed [63:0] HALF47 = 64'sd1 <<< 47;

    logic [4:0] v_reg;
    logic [23:0] rp1_reg, rp2_reg, rp3_reg, rp4_reg, rp5_reg;

    logic signed [24:0] d_reg;
    logic signed [41:0] m1_reg;
    logic signed [49:0] dsq_reg;
    logic signed [61:0] tn_reg;
    logic signed [63:0] tc100_reg;
    logic signed [25:0] tl4_reg, tl5_reg;
    logic signed [14:0] cdeg_reg;
    logic               tflag_reg;

    logic signed [24:0] d_next;
    logic signed [61:0] m1s;
    logic signed [61:0] dt3;
    logic signed [61:0] tn_next;
    logic signed [61:0] tc;
    logic signed [29:0] tsh;
    logic signed [25:0] tl_next;
    logic signed [63:0] tc100_next;
    logic signed [63:0] rnd;
    logic signed [15:0] cd;
    logic signed [14:0] cdeg_next;
    logic               tflag_next;

    assign d_next = $signed({1'b0, raw_temp}) - $signed({1'b0, coef.t1, 8'h00});
    assign m1s    = {{2{m1_reg[41]}}, m1_reg, 18'h0};
    assign dt3    = dsq_reg * coef.t3;
    assign tn_next = m1s + dt3;

    always_comb
    begin
        if (tn_reg > TN_LIM)
            tc = TN_LIM;
        else if (tn_reg < -TN_LIM)
            tc = -TN_LIM;
        else
            tc = tn_reg;
        tsh = tn_reg[61:32];
        if (tsh > TL_LIM)
            tl_next = 26'(TL_LIM);
        else if (tsh < -TL_LIM)
            tl_next = 26'(-TL_LIM);
        else
            tl_next = tsh[25:0];
    end

    assign tc100_next = 64'(tc) * 64'sd100;
    assign rnd        = tc100_reg + HALF47;
    assign cd         = rnd[63:48];

    always_comb
    begin
        tflag_next = 1'b0;
        cdeg_next  = cd[14:0];
        if (cd > TEMP_MAX)
        begin
            tflag_next = 1'b1;
            cdeg_next  = TEMP_MAX[14:0];
        end
        else if (cd < TEMP_MIN)
        begin
            tflag_next = 1'b1;
            cdeg_next  = TEMP_MIN[14:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        d_reg     <= d_next;
        rp1_reg   <= raw_press;
        m1_reg    <= d_reg * $signed({1'b0, coef.t2});
        dsq_reg   <= d_reg * d_reg;
        rp2_reg   <= rp1_reg;
        tn_reg    <= tn_next;
        rp3_reg   <= rp2_reg;
        tc100_reg <= tc100_next;
        tl4_reg   <= tl_next;
        rp4_reg   <= rp3_reg;
        cdeg_reg  <= cdeg_next;
        tflag_reg <= tflag_next;
        tl5_reg   <= tl4_reg;
        rp5_reg   <= rp4_reg;
    end

    assign tout.valid = v_reg[4];
    assign tout.tl    = tl5_reg;
    assign tout.rp    = rp5_reg;
    assign tout.cdeg  = cdeg_reg;
    assign tout.tflag = tflag_reg;

endmodule

// ===== hdl/bcomp_press_pipe.sv =====
// bcomp_press_pipe: six-stage cubic pressure polynomial and saturation
// depends on bcomp_pkg (coef_t, tbeat_t, pressure limit)
module bcomp_press_pipe
    import bcomp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  tbeat_t             tin,
    input  coef_t              coef,
    output logic               done,
    output logic signed [14:0] temp_centideg,
    output logic        [17:0] press_pascal,
    output logic               range_flag
);

    localparam logic signed [47:0] HALF15 = 48'sd1 <<< 15;

    logic [5:0] v_reg;
    logic signed [14:0] cd1_reg, cd2_reg, cd3_reg, cd4_reg, cd5_reg;
    logic tf1_reg, tf2_reg, tf3_reg, tf4_reg, tf5_reg;
    logic signed [24:0] rp1_reg, rp2_reg, rp3_reg, rp4_reg;

    // stage 1
    logic signed [25:0] tl1_reg;
    logic signed [33:0] tl2_1_reg;
    logic signed [42:0] a6_1_reg, a6_2_reg, a6_3_reg;
    logic signed [43:0] a2_1_reg, a2_2_reg, a2_3_reg;
    logic signed [33:0] a10_1_reg;
    logic signed [32:0] q11_1_reg;
    // stage 2
    logic signed [43:0] tl3_2_reg;
    logic signed [41:0] b7_2_reg, b3_2_reg, b7_3_reg, b3_3_reg;
    logic signed [33:0] dd_2_reg;
    logic signed [33:0] q11_2_reg;
    // stage 3
    logic signed [51:0] c8_3_reg, c4_3_reg;
    logic signed [34:0] o3a_3_reg;
    logic signed [33:0] o4_3_reg, o4_4_reg, o4_5_reg;
    // stage 4
    logic signed [47:0] o1_4_reg, o1_5_reg;
    logic signed [35:0] cc_4_reg;
    logic signed [59:0] o3b_4_reg;
    // stage 5
    logic signed [40:0] o2_5_reg;
    logic signed [35:0] o3_5_reg;

    logic signed [24:0] rps;
    logic signed [51:0] tlsq;
    logic signed [17:0] p1m, p2m;
    logic signed [59:0] tlcube;
    logic signed [33:0] dd_next;
    logic signed [57:0] qq;
    logic signed [58:0] dx, qy;
    logic signed [47:0] o1_next;
    logic signed [35:0] cc_next;
    logic signed [60:0] z;
    logic signed [47:0] sum, rnd;
    logic signed [31:0] pa;
    logic        [17:0] pa_next;
    logic               pflag;

    assign rps    = $signed({1'b0, tin.rp});
    assign tlsq   = tin.tl * tin.tl;
    assign p1m    = 18'(coef.p1) - 18'sd16384;
    assign p2m    = 18'(coef.p2) - 18'sd16384;
    assign tlcube = tl2_1_reg * tl1_reg;
    assign dd_next = 34'($signed({coef.p9, 16'h0})) + a10_1_reg;
    assign qq     = q11_1_reg * rp1_reg;
    assign dx     = dd_2_reg * rp2_reg;
    assign qy     = q11_2_reg * rp2_reg;
    assign o1_next = $signed({13'h0, coef.p5, 19'h0}) + 48'(a6_3_reg >>> 6)
                   + 48'(b7_3_reg >>> 8) + 48'(c8_3_reg >>> 15);
    assign cc_next = (36'(p1m) <<< 16) + 36'(a2_3_reg >>> 9)
                   + 36'(b3_3_reg >>> 12) + 36'(c4_3_reg >>> 17);
    assign z      = cc_4_reg * rp4_reg;
    assign sum    = o1_5_reg + 48'(o2_5_reg) + 48'(o3_5_reg) + 48'(o4_5_reg);
    assign rnd    = sum + HALF15;
    assign pa     = rnd[47:16];

    always_comb
    begin
        pflag   = 1'b0;
        pa_next = pa[17:0];
        if (pa < 32'sd0)
        begin
            pflag   = 1'b1;
            pa_next = '0;
        end
        else if (pa > PRESS_MAX)
        begin
            pflag   = 1'b1;
            pa_next = PRESS_MAX[17:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[4:0], tin.valid};
    end

    always_ff @(posedge clk)
    begin
        // stage 1: squares and first-order terms
        cd1_reg   <= tin.cdeg;
        tf1_reg   <= tin.tflag;
        rp1_reg   <= rps;
        tl1_reg   <= tin.tl;
        tl2_1_reg <= tlsq[49:16];
        a6_1_reg  <= tin.tl * $signed({1'b0, coef.p6});
        a2_1_reg  <= tin.tl * p2m;
        a10_1_reg <= tin.tl * coef.p10;
        q11_1_reg <= coef.p11 * rps;
        // stage 2: cube and second-order terms
        cd2_reg   <= cd1_reg;
        tf2_reg   <= tf1_reg;
        rp2_reg   <= rp1_reg;
        tl3_2_reg <= tlcube[59:16];
        b7_2_reg  <= coef.p7 * tl2_1_reg;
        b3_2_reg  <= coef.p3 * tl2_1_reg;
        dd_2_reg  <= dd_next;
        q11_2_reg <= qq[57:24];
        a6_2_reg  <= a6_1_reg;
        a2_2_reg  <= a2_1_reg;
        // stage 3: third-order terms and raw pressure products
        cd3_reg   <= cd2_reg;
        tf3_reg   <= tf2_reg;
        rp3_reg   <= rp2_reg;
        c8_3_reg  <= coef.p8 * tl3_2_reg;
        c4_3_reg  <= coef.p4 * tl3_2_reg;
        o3a_3_reg <= dx[58:24];
        o4_3_reg  <= qy[58:25];
        a6_3_reg  <= a6_2_reg;
        a2_3_reg  <= a2_2_reg;
        b7_3_reg  <= b7_2_reg;
        b3_3_reg  <= b3_2_reg;
        // stage 4: offset and sensitivity sums
        cd4_reg   <= cd3_reg;
        tf4_reg   <= tf3_reg;
        rp4_reg   <= rp3_reg;
        o1_4_reg  <= o1_next;
        cc_4_reg  <= cc_next;
        o3b_4_reg <= o3a_3_reg * rp3_reg;
        o4_4_reg  <= o4_3_reg;
        // stage 5: sensitivity times pressure
        cd5_reg   <= cd4_reg;
        tf5_reg   <= tf4_reg;
        o2_5_reg  <= z[60:20];
        o3_5_reg  <= o3b_4_reg[59:24];
        o1_5_reg  <= o1_4_reg;
        o4_5_reg  <= o4_4_reg;
        // stage 6: round, saturate, output beat
        temp_centideg <= cd5_reg;
        press_pascal  <= pa_next;
        range_flag    <= tf5_reg | pflag;
    end

    assign done = v_reg[5];

endmodule

// ===== hdl/barometer_compensation_core.sv =====
// an accepted start comes out as the done strobe after the temperature and pressure pipelines
// throughput: one beat per cycle, busy is never raised; the receiver cannot stall
// eleven register stages of multipliers set the latency
// reset: rst_n async active low clears the calibration registers and all valid bits
// top level: calibration registers, decoder, temperature and pressure pipelines
// depends on bcomp_pkg, bcomp_temp_pipe, bcomp_press_pipe
module barometer_compensation_core
    import bcomp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [23:0]        raw_temp,
    input  logic [23:0]        raw_press,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [63:0]        wr_data,
    output logic               done,
    output logic signed [14:0] temp_centideg,
    output logic        [17:0] press_pascal,
    output logic               range_flag
);

    logic [63:0] cal_low_reg;
    logic [63:0] cal_mid_reg;
    logic [39:0] cal_high_reg;
    coef_t       coef;
    tbeat_t      tbeat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_low_reg  <= '0;
            cal_mid_reg  <= '0;
            cal_high_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_CAL_LOW:  cal_low_reg  <= wr_data;
                REG_CAL_MID:  cal_mid_reg  <= wr_data;
                REG_CAL_HIGH: cal_high_reg <= wr_data[39:0];
                default:      ;
            endcase
        end
    end

    assign coef = decode_coef({cal_high_reg, cal_mid_reg, cal_low_reg});
    assign busy = 1'b0;

    bcomp_temp_pipe u_temp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .raw_temp  (raw_temp),
        .raw_press (raw_press),
        .coef      (coef),
        .tout      (tbeat)
    );

    bcomp_press_pipe u_press (
        .clk           (clk),
        .rst_n         (rst_n),
        .tin           (tbeat),
        .coef          (coef),
        .done          (done),
        .temp_centideg (temp_centideg),
        .press_pascal  (press_pascal),
        .range_flag    (range_flag)
    );

endmodule

// ===== hdl/bcomp_checker.sv =====
// bcomp_checker: port-level assertions for barometer_compensation_core
// bound to the top level; no package dependencies
module bcomp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [14:0] temp_centideg,
    input logic        [17:0] press_pascal
);

    a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##11 done)
        else $error("accepted beat not delivered after 11 cycles");

    a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 11))
        else $error("result beat without matching accepted beat");

    a_temp_rng: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (temp_centideg >= -15'sd5000) && (temp_centideg <= 15'sd10000))
        else $error("temperature outside saturation range");

    a_press_rng: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> press_pascal <= 18'd200000)
        else $error("pressure outside saturation range");

endmodule

bind barometer_compensation_core bcomp_checker u_bcomp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .temp_centideg (temp_centideg),
    .press_pascal  (press_pascal)
);
